### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sstf_pkg.sv
// ---------------------------------------------------------------------------
// sstf_pkg
// shared types and constants of the seek-time-first disk scheduler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sstf_pkg;

  localparam int CYL_W = 16;
  localparam int SUM_W = 22;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_queue;
    logic add_req;
    logic start_run;
    logic scan_init;
    logic scan_en;
    logic serve;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic run_end;
  } stat_t;

endpackage

### hw/rtl/sstf_disk_schedule.sv
// ---------------------------------------------------------------------------
// sstf_disk_schedule
// shortest-seek-time-first disk scheduler: nearest pending request first
// ---------------------------------------------------------------------------
// channel   ports                               handshake
// input     in_kind, in_cylinder, in_last       start high, busy low
// result    out_served_cylinder, out_move_distance,
//           out_total_seek, out_overflow,
//           out_last_out                        out_valid, one cycle
//
// a load word (kind 0, or kind 1 without last) leaves the block idle, busy stays low
// a run over n held requests serves them one by one: each service scans all
// n entries through the single read port of the request memory, then passes
// the drain state for the last compare and the emit state for the result
// synchronous active-low reset clears control state, head and totals
// results cannot be stalled, busy stays high until the last result of a run
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sstf_disk_schedule import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_kind,
  input  logic [CYL_W-1:0] in_cylinder,
  input  logic             in_last,
  output logic             out_valid,
  output logic [CYL_W-1:0] out_served_cylinder,
  output logic [CYL_W-1:0] out_move_distance,
  output logic [SUM_W-1:0] out_total_seek,
  output logic             out_overflow,
  output logic             out_last_out
);

  cmd_t  cmd;
  stat_t stat;

  sstf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .in_last   (in_last),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sstf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_cylinder         (in_cylinder),
    .stat                (stat),
    .out_served_cylinder (out_served_cylinder),
    .out_move_distance   (out_move_distance),
    .out_total_seek      (out_total_seek),
    .out_overflow        (out_overflow),
    .out_last_out        (out_last_out)
  );

endmodule

### hw/rtl/sstf_ctrl.sv
// ---------------------------------------------------------------------------
// sstf_ctrl
// sequencer: load, scan of held entries, compare drain and service
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sstf_ctrl import sstf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  in_kind,
  input  logic  in_last,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!in_kind) begin
            cmd.clr_queue = 1'b1;
          end else begin
            cmd.add_req = 1'b1;
            if (in_last) begin
              cmd.start_run = 1'b1;
              cmd.scan_init = 1'b1;
              state_nxt     = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.serve = 1'b1;
        if (stat.run_end) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/sstf_dp.sv
// ---------------------------------------------------------------------------
// sstf_dp
// request memory, served marks, nearest-request compare and seek totals
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sstf_dp import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [CYL_W-1:0] in_cylinder,
  output stat_t            stat,
  output logic [CYL_W-1:0] out_served_cylinder,
  output logic [CYL_W-1:0] out_move_distance,
  output logic [SUM_W-1:0] out_total_seek,
  output logic             out_overflow,
  output logic             out_last_out
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(QUEUE_DEPTH);

  logic [CYL_W-1:0]       mem [QUEUE_DEPTH];
  logic [CYL_W-1:0]       rd_data_r;
  logic [QUEUE_DEPTH-1:0] mark_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       srv_cnt_r;
  logic [IDX_W-1:0]       scan_idx_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   cmp_vld_r;
  logic                   found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [CYL_W-1:0]       best_cyl_r;
  logic [CYL_W-1:0]       best_dist_r;
  logic [CYL_W-1:0]       head_r;
  logic [SUM_W-1:0]       sum_r;
  logic                   dropped_r;
  logic                   room;
  logic [CYL_W-1:0]       cur_dist;
  logic                   take;
  logic [SUM_W-1:0]       sum_nxt;

  assign room = (count_r < LIMIT);

  // request memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.add_req && room) begin
      mem[count_r[IDX_W-1:0]] <= in_cylinder;
    end
    rd_data_r <= mem[scan_idx_r];
  end

  assign cur_dist = (head_r >= rd_data_r) ? (head_r - rd_data_r) : (rd_data_r - head_r);
  assign take = cmp_vld_r && !mark_r[cmp_idx_r] && (!found_r || (cur_dist < best_dist_r));

  assign sum_nxt = sum_r + SUM_W'(best_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r     <= '0;
      count_r    <= '0;
      srv_cnt_r  <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      head_r     <= '0;
      sum_r      <= '0;
      dropped_r  <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_en;
      if (cmd.clr_queue) begin
        head_r    <= in_cylinder;
        mark_r    <= '0;
        count_r   <= '0;
        dropped_r <= 1'b0;
        sum_r     <= '0;
      end
      if (cmd.add_req) begin
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd.start_run) begin
        sum_r     <= '0;
        srv_cnt_r <= '0;
      end
      if (cmd.scan_init) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else if (cmd.scan_en) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      if (take) begin
        found_r <= 1'b1;
      end
      if (cmd.serve) begin
        mark_r[best_idx_r] <= 1'b1;
        head_r             <= best_cyl_r;
        sum_r              <= sum_nxt;
        srv_cnt_r          <= srv_cnt_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        mark_r    <= '0;
        count_r   <= '0;
        dropped_r <= 1'b0;
      end
    end
  end

  // best candidate of the current scan
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
    if (take) begin
      best_idx_r  <= cmp_idx_r;
      best_cyl_r  <= rd_data_r;
      best_dist_r <= cur_dist;
    end
  end

  assign stat.scan_end = (CNT_W'(scan_idx_r) == (count_r - CNT_W'(1)));
  assign stat.run_end  = ((srv_cnt_r + CNT_W'(1)) == count_r);

  assign out_served_cylinder = best_cyl_r;
  assign out_move_distance   = best_dist_r;
  assign out_total_seek      = sum_nxt;
  assign out_overflow        = dropped_r;
  assign out_last_out        = stat.run_end;

endmodule

### hw/rtl/sstf_checker.sv
// ---------------------------------------------------------------------------
// sstf_checker
// port-level checks of the scheduler, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sstf_checker import sstf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_kind,
  input logic             in_last,
  input logic             out_valid,
  input logic [CYL_W-1:0] out_move_distance,
  input logic [SUM_W-1:0] out_total_seek
);

  `ASSERT_SAME(a_valid_busy, out_valid, busy, "result word outside a run")
  `ASSERT_NEXT(a_valid_gap, out_valid, !out_valid, "result words back to back")
  `ASSERT_NEXT(a_load_idle, start && !busy && !in_kind, !busy, "head load made block busy")
  `ASSERT_SAME(a_sum_ge, out_valid, SUM_W'(out_move_distance) <= out_total_seek,
    "total seek below move distance")
  `ASSERT_NEXT(a_run_start, start && !busy && in_kind && in_last, busy, "run did not start")

endmodule

bind sstf_disk_schedule sstf_checker u_sstf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_kind           (in_kind),
  .in_last           (in_last),
  .out_valid         (out_valid),
  .out_move_distance (out_move_distance),
  .out_total_seek    (out_total_seek)
);
